@@ hdl/sgcd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgcd_pkg
// Shared types and constants of the Savitzky-Golay central-difference filter.
// ----------------------------------------------------------------------------
package sgcd_pkg;

  // Register map, index of each register (byte address is 4x the index)
  localparam logic [2:0] REG_HALF_WIDTH  = 3'd0;
  localparam logic [2:0] REG_BACK_ADD    = 3'd1;
  localparam logic [2:0] REG_COEF_CENTER = 3'd2;

  localparam int CFG_ADDR_W   = 5;   // eight 32-bit registers
  localparam int CFG_DATA_W   = 32;
  localparam int REG_IDX_W    = 3;
  localparam int HW_REG_W     = 3;   // half_width register width
  localparam int COEF_W       = 24;  // signed Q8.16 coefficients
  localparam int NUM_TAP_COEF = 5;   // coef_1 .. coef_5, higher taps are zero
  localparam int COEF_IDX_W   = 3;   // index into centre + tap coefficients
  localparam int OUT_W        = 32;  // saturated result width

  // Control from the sequencer to the shared multiply-accumulate unit
  typedef struct packed {
    logic clr;     // clear the accumulator
    logic issue;   // start one product this cycle
    logic centre;  // product uses the centre sample alone
    logic sub;     // backward sample is subtracted from the forward one
  } mac_ctrl_t;

endpackage
`default_nettype wire

@@ hdl/sgcd_mac.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgcd_mac
// Shared pre-add, multiply and accumulate unit with floor shift and
// saturation of the accumulated sum to 32 bits.
// ----------------------------------------------------------------------------
module sgcd_mac #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 16,
  parameter int MAX_HALF       = 5
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire sgcd_pkg::mac_ctrl_t                ctrl_i,
  input  wire logic signed [SAMPLE_BITS-1:0]      fwd_i,
  input  wire logic signed [SAMPLE_BITS-1:0]      bwd_i,
  input  wire logic signed [sgcd_pkg::COEF_W-1:0] coef_i,
  output logic signed [sgcd_pkg::OUT_W-1:0]       result_o
);
  import sgcd_pkg::*;

  localparam int PRE_W  = SAMPLE_BITS + 1;
  localparam int PROD_W = COEF_W + PRE_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_HALF + 2);

  logic signed [PRE_W-1:0]  fwd_x;
  logic signed [PRE_W-1:0]  bwd_x;
  logic signed [PRE_W-1:0]  pre;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_vld_d;
  logic                     prod_vld_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-OUT_W:0]     hi_bits;

  // Tap pair pre-add
  assign fwd_x = PRE_W'(fwd_i);
  assign bwd_x = PRE_W'(bwd_i);

  always_comb begin
    if (ctrl_i.centre) begin
      pre = fwd_x;
    end else if (ctrl_i.sub) begin
      pre = fwd_x - bwd_x;
    end else begin
      pre = fwd_x + bwd_x;
    end
  end

  // Product is registered before it reaches the accumulator
  assign prod_d     = coef_i * pre;
  assign prod_vld_d = ctrl_i.issue;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= prod_vld_d;
      acc_q      <= acc_d;
    end
  end

  // Floor shift, then clamp to the signed 32-bit range
  assign shifted = acc_q >>> COEF_FRAC_BITS;
  assign hi_bits = shifted[ACC_W-1:OUT_W-1];

  always_comb begin
    if ((&hi_bits) || !(|hi_bits)) begin
      result_o = shifted[OUT_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      result_o = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      result_o = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

endmodule
`default_nettype wire

@@ hdl/savgol_central_difference_filter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// savgol_central_difference_filter
// Savitzky-Golay style central-difference filter over streamed records.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one sample per beat, tlast on the last sample of a record.
//   m_axis carries one filtered value per beat, tlast on the record's last
//   output. Outputs lag the input by M = half_width samples; the last input
//   beat flushes the pending M outputs, the edge sample repeated as padding.
//   The APB port sets half_width, back_add and the Q8.16 coefficients; write
//   it only while no record output is pending.
//   Each output runs through the shared multiply-accumulate unit in the
//   states MAC (M+1 tap-pair products), ADD (accumulate) and FIN (result).
//   No new sample is accepted while an output is being computed. The last
//   beat first shifts in one padding sample per PAD step, then releases
//   its outputs, each through the same MAC, ADD and FIN states.
//   s_axis_tready is high only while the sequencer is idle. A finished value
//   waits in the output register; a stalled receiver holds the sequencer at
//   its result cycle until that register frees up.
//   Reset clears the window, the fill count and the registers to their
//   defaults (half_width 2, back_add 1, coefficients 0).
// ----------------------------------------------------------------------------
module savgol_central_difference_filter #(
  parameter int MAX_HALF       = 5,
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 16,
  localparam int IN_TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // input stream
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]                s_axis_tdata,  // sample
  input  wire logic                                 s_axis_tlast,  // record_end
  // output stream
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic [sgcd_pkg::OUT_W-1:0]                m_axis_tdata,  // filtered
  output logic                                      m_axis_tlast,  // final_output
  // configuration
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [sgcd_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire logic [sgcd_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [sgcd_pkg::CFG_DATA_W-1:0]           prdata,
  output logic                                      pready
);
  import sgcd_pkg::*;

  localparam int WIN_LEN   = 2 * MAX_HALF + 1;
  localparam int WIN_IDX_W = $clog2(WIN_LEN);
  localparam int HW_W      = $clog2(MAX_HALF + 1);

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_MAC  = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  // Configuration registers
  logic [HW_REG_W-1:0]      half_width_q;
  logic                     back_add_q;
  logic signed [COEF_W-1:0] coef_q [NUM_TAP_COEF+1];
  logic [REG_IDX_W-1:0]     reg_idx;
  logic [COEF_IDX_W-1:0]    wr_coef_idx;
  logic                     cfg_wr;

  // Window and sequencer
  logic signed [SAMPLE_BITS-1:0] win_d [WIN_LEN];
  logic signed [SAMPLE_BITS-1:0] win_q [WIN_LEN];
  logic signed [SAMPLE_BITS-1:0] x_d, x_q;
  logic [2:0]                    st_d, st_q;
  logic [HW_W-1:0]               fill_d, fill_q;
  logic                          in_rec_d, in_rec_q;
  logic [HW_W-1:0]               pad_d, pad_q;
  logic [HW_W-1:0]               tail_d, tail_q;
  logic [HW_W-1:0]               k_d, k_q;
  logic                          last_d, last_q;
  logic [HW_W-1:0]               m_eff;
  logic [HW_W-1:0]               fill_sat;
  logic [HW_W-1:0]               fill_new;
  logic                          in_acc;
  logic                          shift_en;
  logic                          fill_all;
  logic signed [SAMPLE_BITS-1:0] shift_val;

  // Output register
  logic                     out_vld_d, out_vld_q;
  logic [OUT_W-1:0]         out_data_d, out_data_q;
  logic                     out_last_d, out_last_q;
  logic                     out_load;

  // MAC operands
  logic [WIN_IDX_W-1:0]          fwd_idx;
  logic [WIN_IDX_W-1:0]          bwd_idx;
  logic [COEF_IDX_W-1:0]         coef_idx;
  logic signed [COEF_W-1:0]      coef_sel;
  logic signed [OUT_W-1:0]       mac_result;
  mac_ctrl_t                     mac_ctrl;

  // ---------------------------------------------------------------------------
  // APB register file
  // ---------------------------------------------------------------------------
  assign pready      = 1'b1;
  assign reg_idx     = paddr[CFG_ADDR_W-1:2];
  assign wr_coef_idx = COEF_IDX_W'(reg_idx - REG_COEF_CENTER);
  assign cfg_wr      = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q <= HW_REG_W'(2);
      back_add_q   <= 1'b1;
      for (int i = 0; i <= NUM_TAP_COEF; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_HALF_WIDTH: half_width_q <= pwdata[HW_REG_W-1:0];
        REG_BACK_ADD:   back_add_q   <= pwdata[0];
        default:        coef_q[wr_coef_idx] <= pwdata[COEF_W-1:0];
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HALF_WIDTH: prdata = CFG_DATA_W'(half_width_q);
      REG_BACK_ADD:   prdata = CFG_DATA_W'(back_add_q);
      default:        prdata = CFG_DATA_W'(unsigned'(coef_q[wr_coef_idx]));
    endcase
  end

  // Effective half width, clamped to 1..MAX_HALF
  always_comb begin
    if (half_width_q == '0) begin
      m_eff = HW_W'(1);
    end else if (int'(half_width_q) > MAX_HALF) begin
      m_eff = HW_W'(MAX_HALF);
    end else begin
      m_eff = HW_W'(half_width_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign s_axis_tready = (st_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign fill_sat      = (fill_q > m_eff) ? m_eff : fill_q;
  assign out_load      = (st_q == ST_FIN) && (!out_vld_q || m_axis_tready);

  always_comb begin
    if (!in_rec_q) begin
      fill_new = '0;
    end else if (fill_sat < m_eff) begin
      fill_new = fill_sat + HW_W'(1);
    end else begin
      fill_new = fill_sat;
    end
  end

  always_comb begin
    st_d      = st_q;
    x_d       = x_q;
    fill_d    = fill_q;
    in_rec_d  = in_rec_q;
    pad_d     = pad_q;
    tail_d    = tail_q;
    last_d    = last_q;
    k_d       = '0;
    shift_en  = 1'b0;
    fill_all  = 1'b0;
    shift_val = x_q;
    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          x_d       = s_axis_tdata[SAMPLE_BITS-1:0];
          shift_val = s_axis_tdata[SAMPLE_BITS-1:0];
          shift_en  = in_rec_q;
          fill_all  = !in_rec_q;
          if (s_axis_tlast) begin
            // flush: pad with the last sample, then emit fill_new + 1 values
            fill_d   = '0;
            in_rec_d = 1'b0;
            pad_d    = m_eff - fill_new;
            tail_d   = fill_new;
            st_d     = ST_PAD;
          end else begin
            fill_d   = fill_new;
            in_rec_d = 1'b1;
            tail_d   = '0;
            if (fill_new == m_eff) begin
              last_d = 1'b0;
              st_d   = ST_MAC;
            end
          end
        end
      end
      ST_PAD: begin
        if (pad_q != '0) begin
          shift_en = 1'b1;
          pad_d    = pad_q - HW_W'(1);
        end else begin
          last_d = (tail_q == '0);
          st_d   = ST_MAC;
        end
      end
      ST_MAC: begin
        if (k_q == m_eff) begin
          st_d = ST_ADD;
        end else begin
          k_d = k_q + HW_W'(1);
        end
      end
      ST_ADD: begin
        st_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) begin
          if (tail_q != '0) begin
            shift_en = 1'b1;
            tail_d   = tail_q - HW_W'(1);
            last_d   = (tail_q == HW_W'(1));
            st_d     = ST_MAC;
          end else begin
            st_d = ST_IDLE;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // Window: shift in the newest sample, or fill with the first of a record
  always_comb begin
    win_d = win_q;
    if (fill_all) begin
      for (int j = 0; j < WIN_LEN; j++) begin
        win_d[j] = shift_val;
      end
    end else if (shift_en) begin
      for (int j = 1; j < WIN_LEN; j++) begin
        win_d[j] = win_q[j-1];
      end
      win_d[0] = shift_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      fill_q   <= '0;
      in_rec_q <= 1'b0;
      pad_q    <= '0;
      tail_q   <= '0;
      k_q      <= '0;
      last_q   <= 1'b0;
      for (int j = 0; j < WIN_LEN; j++) begin
        win_q[j] <= '0;
      end
    end else begin
      st_q     <= st_d;
      fill_q   <= fill_d;
      in_rec_q <= in_rec_d;
      pad_q    <= pad_d;
      tail_q   <= tail_d;
      k_q      <= k_d;
      last_q   <= last_d;
      win_q    <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
  end

  // ---------------------------------------------------------------------------
  // Operand selection for the shared MAC (k = 0 is the centre tap)
  // ---------------------------------------------------------------------------
  assign fwd_idx  = WIN_IDX_W'(m_eff) - WIN_IDX_W'(k_q);
  assign bwd_idx  = WIN_IDX_W'(m_eff) + WIN_IDX_W'(k_q);
  assign coef_idx = COEF_IDX_W'(k_q);

  always_comb begin
    if (int'(k_q) <= NUM_TAP_COEF) begin
      coef_sel = coef_q[coef_idx];
    end else begin
      coef_sel = '0;
    end
  end

  // accumulator is kept while a finished sum waits at the result cycle
  always_comb begin
    if (st_q == ST_FIN) begin
      mac_ctrl.clr = out_load;
    end else begin
      mac_ctrl.clr = (st_q != ST_MAC) && (st_q != ST_ADD);
    end
    mac_ctrl.issue  = (st_q == ST_MAC);
    mac_ctrl.centre = (k_q == '0);
    mac_ctrl.sub    = !back_add_q;
  end

  sgcd_mac #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS),
    .MAX_HALF      (MAX_HALF)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .fwd_i   (win_q[fwd_idx]),
    .bwd_i   (win_q[bwd_idx]),
    .coef_i  (coef_sel),
    .result_o(mac_result)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_comb begin
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_data_d = out_data_q;
    out_last_d = out_last_q;
    if (out_load) begin
      out_vld_d  = 1'b1;
      out_data_d = mac_result;
      out_last_d = last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire
